>>> sv/xfrlm_pkg.sv
// Shared types and constants for the frame receiver and link monitor.
package xfrlm_pkg;

  localparam int HEADER_BYTES_DEF = 4;

  localparam logic [7:0] SYNC_TYPE       = 8'hFE;
  localparam logic [8:0] UNACKED_MAX     = 9'd511;
  localparam logic [7:0] ACK_LIMIT_RESET = 8'd60;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_CTRL = 2'd1,
    SEND_SYNC = 2'd2
  } send_kind_t;

  // Declared from the top bit down, so the packed form is the stream word.
  typedef struct packed {
    logic [8:0] unacked;
    logic       link_lost;
    logic       link_up;
    send_kind_t send_kind;
    logic       header_slip;
    logic [7:0] frame_type;
    logic       frame_good;
    logic       frame_done;
  } result_t;

endpackage

>>> sv/xfrlm_core.sv
// Header window, frame tracking and link state with the per-request update logic.
module xfrlm_core #(
  parameter int HEADER_BYTES = xfrlm_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          ack_limit,
  output xfrlm_pkg::result_t  result
);

  localparam int IW = $clog2(HEADER_BYTES);
  localparam logic [7:0] HB = 8'(HEADER_BYTES);

  logic [7:0] window      [HEADER_BYTES];
  logic [7:0] window_next [HEADER_BYTES];
  logic [7:0] window_w    [HEADER_BYTES];
  logic [7:0] prefix      [HEADER_BYTES + 1];
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_xor, running_xor_next;
  logic       linked, linked_next;
  logic [8:0] unacked, unacked_next;

  logic       hdr_phase;
  logic       hdr_full;
  logic [7:0] full_xor;
  logic [7:0] short_xor;
  logic [7:0] body_count;
  logic [8:0] unacked_inc;
  logic       close;
  logic [7:0] close_xor;
  logic [7:0] type_byte;

  assign hdr_phase = byte_count < HB;
  assign hdr_full  = byte_count == (HB - 8'd1);

  // Window as it stands once the incoming byte is written in.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      window_w[i] = (byte_count[IW-1:0] == IW'(i)) ? rx_byte : window[i];
    end
    prefix[0] = 8'd0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      prefix[i+1] = prefix[i] ^ window_w[i];
    end
  end

  assign full_xor = prefix[HEADER_BYTES];

  always_comb begin
    short_xor = 8'd0;
    for (int k = 0; k <= HEADER_BYTES; k++) begin
      if (window_w[2] == 8'(k)) begin
        short_xor = prefix[k];
      end
    end
  end

  assign body_count  = (byte_count != 8'd255) ? byte_count + 8'd1 : byte_count;
  assign unacked_inc = (unacked < xfrlm_pkg::UNACKED_MAX) ? unacked + 9'd1 : unacked;
  assign type_byte   = hdr_phase ? window_w[1] : window[1];

  always_comb begin
    window_next       = window;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    running_xor_next  = running_xor;
    linked_next       = linked;
    unacked_next      = unacked;
    close             = 1'b0;
    close_xor         = 8'd0;
    result            = '0;
    result.send_kind  = xfrlm_pkg::SEND_NONE;

    if (command) begin
      if (linked) begin
        result.send_kind = xfrlm_pkg::SEND_CTRL;
        unacked_next     = unacked_inc;
        if (unacked_inc > {1'b0, ack_limit}) begin
          linked_next      = 1'b0;
          result.link_lost = 1'b1;
        end
      end else begin
        result.send_kind = xfrlm_pkg::SEND_SYNC;
      end
    end else begin
      if (hdr_phase) begin
        window_next      = window_w;
        byte_count_next  = byte_count + 8'd1;
        running_xor_next = running_xor ^ rx_byte;
        if (hdr_full) begin
          if (full_xor != 8'd0) begin
            // Drop the oldest byte and keep looking for a header.
            result.header_slip = 1'b1;
            for (int i = 0; i < HEADER_BYTES - 1; i++) begin
              window_next[i] = window_w[i+1];
            end
            window_next[HEADER_BYTES-1] = 8'd0;
            byte_count_next  = HB - 8'd1;
            running_xor_next = full_xor ^ window_w[0];
          end else begin
            frame_length_next = window_w[2];
            if (window_w[2] <= HB) begin
              close     = 1'b1;
              close_xor = short_xor;
            end
          end
        end
      end else begin
        running_xor_next = running_xor ^ rx_byte;
        byte_count_next  = body_count;
        if (body_count >= frame_length) begin
          close     = 1'b1;
          close_xor = running_xor ^ rx_byte;
        end
      end

      if (close) begin
        result.frame_done = 1'b1;
        result.frame_type = type_byte;
        if (close_xor == 8'd0) begin
          result.frame_good = 1'b1;
          if (type_byte == xfrlm_pkg::SYNC_TYPE) begin
            linked_next  = 1'b1;
            unacked_next = 9'd0;
          end
        end
        for (int i = 0; i < HEADER_BYTES; i++) begin
          window_next[i] = 8'd0;
        end
        byte_count_next   = 8'd0;
        frame_length_next = HB;
        running_xor_next  = 8'd0;
      end
    end

    result.link_up = linked_next;
    result.unacked = unacked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        window[i] <= 8'd0;
      end
      byte_count   <= 8'd0;
      frame_length <= HB;
      running_xor  <= 8'd0;
      linked       <= 1'b0;
      unacked      <= 9'd0;
    end else if (step) begin
      window       <= window_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_xor  <= running_xor_next;
      linked       <= linked_next;
      unacked      <= unacked_next;
    end
  end

endmodule

>>> sv/xor_frame_receiver_link_monitor.sv
// Top level of the frame receiver and link monitor with input and result registers.
// A request goes to the input register and its result to the result register.
// Throughput: one request per cycle unless stalled; the registers form a two-stage pipe.
// A stalled result holds the pipe only once the input register is also full.
// Reset clears the frame state, the link state, the unacked count and both valid flags.
// Reset sets ack_limit to 60.
module xor_frame_receiver_link_monitor #(
  parameter int HEADER_BYTES = xfrlm_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_done[0], frame_good[1], frame_type[9:2], header_slip[10], send_kind[12:11],
  // link_up[13], link_lost[14], unacked[23:15]
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic               s1_valid;
  logic               s1_command;
  logic [7:0]         s1_byte;
  logic               advance;
  logic [7:0]         ack_limit;
  xfrlm_pkg::result_t core_result;
  xfrlm_pkg::result_t out_word;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit <= xfrlm_pkg::ACK_LIMIT_RESET;
    end else if (cfg_we) begin
      ack_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_command <= s_tuser;
      s1_byte    <= s_tdata;
    end
  end

  xfrlm_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .command   (s1_command),
    .rx_byte   (s1_byte),
    .ack_limit (ack_limit),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= core_result;
    end
  end

  assign m_tdata = out_word;

endmodule
